FILE: rtl/srfc_pkg.sv
// Package: constants for the sensor reply frame checker.
`timescale 1ns / 1ps
`default_nettype none
package srfc_pkg;

  localparam logic [7:0]  IDLE_BYTE    = 8'hff;
  localparam logic [15:0] DIST_INVALID = 16'hffff;
  localparam logic [3:0]  MIN_LEN      = 4'd2;
  localparam logic [3:0]  MAX_LEN      = 4'd8;
  localparam logic [3:0]  LEN_RESET    = 4'd8;
  localparam logic [2:0]  HI_POS       = 3'd5;
  localparam logic [2:0]  LO_POS       = 3'd6;
  localparam int          MAG_W        = 12;
  localparam int          QUO_W        = 9;
  localparam int          TEMP_W       = 10;
  // x / 10 == (x * 3277) >> 15 for any 12-bit x
  localparam logic [MAG_W-1:0] DIV10_MUL = 12'd3277;
  localparam int               DIV10_SHR = 15;

  typedef logic [MAG_W-1:0]   mag_t;
  typedef logic [2*MAG_W-1:0] prod_t;

endpackage
`default_nettype wire

FILE: rtl/sensor_reply_frame_checker.sv
// Result path: a frame's last byte goes into the frame register, then on to out_ through the output register.
// Throughput: one byte per cycle while in_stall is low; the result path is a two-register pipeline
// (frame register, then divide-by-ten multiply into the output register).
// Reset (rst_n low, synchronous): frame state and pipeline valids clear,
// frame_length returns to 8. No clearing pass.
// Top level: ranging sensor reply frame checker.
`timescale 1ns / 1ps
`default_nettype none
module sensor_reply_frame_checker (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire                in_start_frame,
  input  wire         [7:0]  in_rx_byte,
  output logic               out_valid,
  input  wire                out_stall,
  output logic               out_frame_ok,
  output logic        [15:0] out_distance,
  output logic signed [9:0]  out_temperature,
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire         [3:0]  cfg_frame_length
);

  logic [3:0] len_r;
  logic [2:0] cnt_r, cnt_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic       fnz_r, fnz_nxt;
  logic [7:0] hi_r, hi_nxt;
  logic [7:0] lo_r, lo_nxt;

  logic       s1_valid_r, s1_valid_nxt;
  logic       s1_ok_r;
  logic [7:0] s1_hi_r, s1_lo_r;

  logic              out_valid_r;
  logic              out_ok_r;
  logic [15:0]       out_dist_r;
  logic signed [9:0] out_temp_r;

  logic       in_acc, out_adv, s1_adv;
  logic [2:0] cnt_e;
  logic [7:0] sum_e, hi_e, lo_e, hi_use, lo_use;
  logic       fnz_e, fnz_use, is_idle, is_last, ok;
  logic [3:0] len_eff;

  srfc_pkg::mag_t mag;
  srfc_pkg::prod_t prod;
  logic [srfc_pkg::QUO_W-1:0] quo;
  logic signed [9:0] temp_val;

  assign cfg_ready = 1'b1;

  assign out_adv  = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_adv;
  assign in_stall = s1_valid_r && !out_adv;
  assign in_acc   = in_valid && !in_stall;

  assign len_eff = (len_r < srfc_pkg::MIN_LEN) ? srfc_pkg::MIN_LEN :
                   (len_r > srfc_pkg::MAX_LEN) ? srfc_pkg::MAX_LEN : len_r;

  always_comb begin
    cnt_e = in_start_frame ? 3'd0 : cnt_r;
    sum_e = in_start_frame ? 8'd0 : sum_r;
    fnz_e = in_start_frame ? 1'b0 : fnz_r;
    hi_e  = in_start_frame ? 8'd0 : hi_r;
    lo_e  = in_start_frame ? 8'd0 : lo_r;
    is_idle = (in_rx_byte == srfc_pkg::IDLE_BYTE);
    fnz_use = (cnt_e == 3'd0) ? (in_rx_byte != 8'd0) : fnz_e;
    hi_use  = (cnt_e == srfc_pkg::HI_POS) ? in_rx_byte : hi_e;
    lo_use  = (cnt_e == srfc_pkg::LO_POS) ? in_rx_byte : lo_e;
    is_last = ({1'b0, cnt_e} + 4'd1) >= len_eff;
    ok      = fnz_use && (sum_e == in_rx_byte);

    cnt_nxt = cnt_r;
    sum_nxt = sum_r;
    fnz_nxt = fnz_r;
    hi_nxt  = hi_r;
    lo_nxt  = lo_r;
    if (in_acc) begin
      if (is_idle) begin
        cnt_nxt = cnt_e;
        sum_nxt = sum_e;
        fnz_nxt = fnz_e;
        hi_nxt  = hi_e;
        lo_nxt  = lo_e;
      end else if (is_last) begin
        cnt_nxt = 3'd0;
        sum_nxt = 8'd0;
        fnz_nxt = 1'b0;
        hi_nxt  = 8'd0;
        lo_nxt  = 8'd0;
      end else begin
        cnt_nxt = cnt_e + 3'd1;
        sum_nxt = sum_e + in_rx_byte;
        fnz_nxt = fnz_use;
        hi_nxt  = hi_use;
        lo_nxt  = lo_use;
      end
    end
  end

  assign s1_valid_nxt = (in_acc && !is_idle && is_last) || (s1_valid_r && !s1_adv);

  // divide by ten through a reciprocal multiply
  assign mag  = {s1_hi_r[3:0], s1_lo_r};
  assign prod = srfc_pkg::prod_t'(mag) * srfc_pkg::prod_t'(srfc_pkg::DIV10_MUL);
  assign quo  = prod[srfc_pkg::DIV10_SHR +: srfc_pkg::QUO_W];
  assign temp_val = (s1_hi_r[7:4] != 4'd0) ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= srfc_pkg::LEN_RESET;
      cnt_r       <= 3'd0;
      sum_r       <= 8'd0;
      fnz_r       <= 1'b0;
      hi_r        <= 8'd0;
      lo_r        <= 8'd0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        len_r <= cfg_frame_length;
      end
      cnt_r      <= cnt_nxt;
      sum_r      <= sum_nxt;
      fnz_r      <= fnz_nxt;
      hi_r       <= hi_nxt;
      lo_r       <= lo_nxt;
      s1_valid_r <= s1_valid_nxt;
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && !is_idle && is_last) begin
      s1_ok_r <= ok;
      s1_hi_r <= hi_use;
      s1_lo_r <= lo_use;
    end
    if (s1_adv) begin
      out_ok_r   <= s1_ok_r;
      out_dist_r <= s1_ok_r ? {s1_hi_r, s1_lo_r} : srfc_pkg::DIST_INVALID;
      out_temp_r <= s1_ok_r ? temp_val : 10'sd0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_frame_ok    = out_ok_r;
  assign out_distance    = out_dist_r;
  assign out_temperature = out_temp_r;

`ifndef ASSERT_OFF
  a_bad_frame_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ok_r) |-> (out_dist_r == srfc_pkg::DIST_INVALID && out_temp_r == 10'sd0))
    else $error("bad frame result not forced to invalid values");
  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_temp_r <= 10'sd409 && out_temp_r >= -10'sd409))
    else $error("temperature out of range");
  a_idle_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_idle && !in_start_frame) |=> $stable(cnt_r) && $stable(sum_r))
    else $error("idle byte changed frame state");
  a_stall_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && out_stall) |-> in_stall)
    else $error("input taken while result pipeline is full");
  a_s1_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> s1_valid_r && $stable(s1_hi_r) && $stable(s1_lo_r))
    else $error("pending frame lost or changed");
`endif

endmodule
`default_nettype wire

FILE: bench/srfc_frame_monitor.sv
// Checker: predicts sensor reply frame results and compares them with the result channel.
`timescale 1ns / 1ps
module srfc_frame_monitor (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  input  wire               in_stall,
  input  wire               in_start_frame,
  input  wire        [7:0]  in_rx_byte,
  input  wire               out_valid,
  input  wire               out_stall,
  input  wire               out_frame_ok,
  input  wire        [15:0] out_distance,
  input  wire signed [9:0]  out_temperature,
  input  wire               cfg_valid,
  input  wire               cfg_ready,
  input  wire        [3:0]  cfg_frame_length,
  output int                n_errors,
  output int                n_pending
);

  typedef struct packed {
    logic        ok;
    logic [15:0] dist_val;
    logic [9:0]  temp;
  } frame_result_t;

  frame_result_t result_q[$];
  int            err_cnt = 0;

  logic [3:0] len_reg;
  logic [3:0] byte_cnt;
  logic [7:0] run_sum;
  logic       first_nz;
  logic [7:0] hi_byte;
  logic [7:0] lo_byte;

  assign n_errors = err_cnt;

  function automatic void clear_gathered();
    byte_cnt = '0;
    run_sum  = '0;
    first_nz = 1'b0;
    hi_byte  = '0;
    lo_byte  = '0;
  endfunction

  always @(posedge clk) begin : track
    frame_result_t want;
    logic [3:0]    eff_len;
    logic [9:0]    mag;
    logic [7:0]    b;
    if (!rst_n) begin
      len_reg = srfc_pkg::LEN_RESET;
      clear_gathered();
      result_q.delete();
    end else begin
      if (cfg_valid && cfg_ready)
        len_reg = cfg_frame_length;

      if (in_valid && !in_stall) begin
        b = in_rx_byte;
        if (in_start_frame)
          clear_gathered();
        if (b != srfc_pkg::IDLE_BYTE) begin
          eff_len = (len_reg < srfc_pkg::MIN_LEN) ? srfc_pkg::MIN_LEN :
                    (len_reg > srfc_pkg::MAX_LEN) ? srfc_pkg::MAX_LEN : len_reg;
          if (byte_cnt == 4'd0)
            first_nz = (b != 8'd0);
          if (byte_cnt == 4'(srfc_pkg::HI_POS))
            hi_byte = b;
          if (byte_cnt == 4'(srfc_pkg::LO_POS))
            lo_byte = b;
          if (int'(byte_cnt) + 1 >= int'(eff_len)) begin
            want.ok = first_nz && (run_sum == b);
            if (want.ok) begin
              want.dist_val = {hi_byte, lo_byte};
              mag = 10'({hi_byte[3:0], lo_byte} / 12'd10);
              want.temp = (hi_byte[7:4] != 4'd0) ? 10'd0 - mag : mag;
            end else begin
              want.dist_val = srfc_pkg::DIST_INVALID;
              want.temp = '0;
            end
            result_q.push_back(want);
            clear_gathered();
          end else begin
            run_sum  = run_sum + b;
            byte_cnt = byte_cnt + 4'd1;
          end
        end
      end

      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result ok=%0d distance=%0d temperature=%0d",
                   $time, out_frame_ok, out_distance, out_temperature);
        end else begin
          want = result_q.pop_front();
          if (out_frame_ok !== want.ok) begin
            err_cnt++;
            $display("%0t: frame_ok expected %0d actual %0d", $time, want.ok, out_frame_ok);
          end
          if (out_distance !== want.dist_val) begin
            err_cnt++;
            $display("%0t: distance expected %0d actual %0d",
                     $time, want.dist_val, out_distance);
          end
          if (out_temperature !== want.temp) begin
            err_cnt++;
            $display("%0t: temperature expected %0d actual %0d",
                     $time, $signed(want.temp), out_temperature);
          end
        end
      end
    end
    n_pending <= result_q.size();
  end

endmodule

FILE: bench/tb_sensor_reply_frame_checker.sv
// Testbench top: stimulus, stall generation, watchdog and verdict for the frame checker.
`timescale 1ns / 1ps
module tb_sensor_reply_frame_checker;

  typedef logic [7:0] byte_q_t[$];

  localparam int ITEM_TARGET    = 1650;
  localparam int WATCHDOG_LIMIT = 3000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_start_frame;
  logic        [7:0]  in_rx_byte;
  logic               out_valid;
  logic               out_stall;
  logic               out_frame_ok;
  logic        [15:0] out_distance;
  logic signed [9:0]  out_temperature;
  logic               cfg_valid;
  logic               cfg_ready;
  logic        [3:0]  cfg_frame_length;

  int   n_errors;
  int   n_pending;
  int   n_sent = 0;
  int   idle_cycles = 0;
  int   stall_left = 0;
  logic stall_state = 1'b0;
  logic fast_phase = 1'b0;
  logic [3:0] cur_len = srfc_pkg::LEN_RESET;

  sensor_reply_frame_checker uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_start_frame   (in_start_frame),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_ok     (out_frame_ok),
    .out_distance     (out_distance),
    .out_temperature  (out_temperature),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_frame_length (cfg_frame_length)
  );

  srfc_frame_monitor frame_mon (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_start_frame   (in_start_frame),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_ok     (out_frame_ok),
    .out_distance     (out_distance),
    .out_temperature  (out_temperature),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_frame_length (cfg_frame_length),
    .n_errors         (n_errors),
    .n_pending        (n_pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result-side backpressure: runs of no stall, short stalls, occasional long ones
  always @(posedge clk) begin : stall_gen
    int r;
    if (stall_left == 0) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        stall_state = 1'b0;
        stall_left  = $urandom_range(1, 25);
      end else if (r < 95) begin
        stall_state = 1'b1;
        stall_left  = $urandom_range(1, 3);
      end else begin
        stall_state = 1'b1;
        stall_left  = $urandom_range(10, 40);
      end
    end
    stall_left = stall_left - 1;
    out_stall <= stall_state;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_byte(input logic s, input logic [7:0] b);
    int gap;
    int r;
    r = $urandom_range(0, 99);
    if (fast_phase || r < 60)
      gap = 0;
    else if (r < 90)
      gap = $urandom_range(1, 3);
    else if (r < 98)
      gap = $urandom_range(4, 10);
    else
      gap = $urandom_range(20, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_start_frame <= s;
    in_rx_byte     <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (b != srfc_pkg::IDLE_BYTE)
      n_sent++;
  endtask

  // data bytes with occasional idle bytes between, then their 8-bit sum xor ck_flip as the closing byte
  task automatic send_frame(input logic s, input byte_q_t data, input logic [7:0] ck_flip);
    logic [7:0] ck;
    ck = '0;
    foreach (data[i]) begin
      if ($urandom_range(0, 99) < 3)
        send_byte(1'b0, srfc_pkg::IDLE_BYTE);
      send_byte(s && i == 0, data[i]);
      ck = ck + data[i];
    end
    send_byte(1'b0, ck ^ ck_flip);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
  endtask

  task automatic set_length(input logic [3:0] len);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_valid        <= 1'b1;
    cfg_frame_length <= len;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_len = len;
  endtask

  initial begin
    byte_q_t    data;
    logic [3:0] eff_len;
    logic [7:0] flip;
    int         phase;
    int         phase_end;

    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_start_frame   = 1'b0;
    in_rx_byte       = 8'd0;
    cfg_valid        = 1'b0;
    cfg_frame_length = 4'd0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // start flag on an idle byte drops the partial frame
    send_byte(1'b0, 8'h33);
    send_byte(1'b1, srfc_pkg::IDLE_BYTE);
    // largest positive temperature, then largest negative
    send_frame(1'b0, '{8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h0f, 8'hfe}, 8'h00);
    send_frame(1'b1, '{8'h80, 8'h11, 8'h22, 8'h33, 8'h44, 8'h1f, 8'hfe}, 8'h00);
    // shortest frames: zero first byte, then bad checksum; length 0 acts as 2
    set_length(4'd2);
    send_frame(1'b1, '{8'h00}, 8'h00);
    set_length(4'd0);
    send_frame(1'b0, '{8'h7f}, 8'h01);
    // length cut below the bytes already gathered
    set_length(4'd8);
    send_byte(1'b1, 8'h05);
    send_byte(1'b0, 8'h06);
    send_byte(1'b0, 8'h07);
    set_length(4'd3);
    send_byte(1'b0, 8'h12);

    phase = 0;
    while (n_sent < ITEM_TARGET) begin
      case (phase)
        0:       set_length(4'd15);
        1:       set_length(4'd1);
        2:       set_length(4'd9);
        default: set_length(4'($urandom_range(0, 15)));
      endcase
      phase++;
      fast_phase = ($urandom_range(0, 3) == 0);
      eff_len = (cur_len < srfc_pkg::MIN_LEN) ? srfc_pkg::MIN_LEN :
                (cur_len > srfc_pkg::MAX_LEN) ? srfc_pkg::MAX_LEN : cur_len;
      phase_end = n_sent + $urandom_range(60, 120);
      while (n_sent < phase_end && n_sent < ITEM_TARGET) begin
        if ($urandom_range(0, 99) < 80) begin
          data.delete();
          for (int i = 0; i < int'(eff_len) - 1; i++) begin
            if (i == 0 && $urandom_range(0, 9) == 0)
              data.push_back(8'h00);
            else
              data.push_back(8'($urandom_range(0, 254)));
          end
          flip = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
          send_frame(1'($urandom_range(0, 1)), data, flip);
          if ($urandom_range(0, 49) == 0)
            wait_drained();
        end else begin
          send_byte($urandom_range(0, 3) == 0, 8'($urandom_range(0, 255)));
        end
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (n_errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
